### sv/gha_pkg.sv
// Shared definitions for the generational handle allocator.
// Operation codes and default sizes; no dependencies.
package gha_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int GEN_BITS_DEF  = 16;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

endpackage

### sv/generational_handle_allocator_core.sv
// Generational handle allocator: create, destroy and check of (id, generation) handles.
// Holds the generation memory and the LIFO free-id stack; depends on gha_pkg.
//
//   channel  signals                                            direction
//   in       in_valid in_stall in_op in_handle_id               request in
//            in_handle_generation
//   out      out_valid out_stall out_id out_generation out_ok   response out
//
// Destroy, check, fresh create and a full create read the generation and stack memories
// on accept, then decide and write in S_RD. A create that reuses a freed id goes on to
// S_POP, as its generation read waits for the stack read.
// Reset clears the state, the counters and the output valid only; a fresh create
// writes its generation entry to zero and ids at or above the fresh-id counter are
// never matched, so no clearing pass is needed. A stalled response holds the last
// cycle of a request until the output register is free.
module generational_handle_allocator_core #(
  parameter int MAX_SLOTS = gha_pkg::MAX_SLOTS_DEF,
  parameter int GEN_BITS  = gha_pkg::GEN_BITS_DEF,
  localparam int ID_W     = $clog2(MAX_SLOTS),
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [ID_W-1:0]     in_handle_id,
  input  logic [GEN_BITS-1:0] in_handle_generation,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ID_W-1:0]     out_id,
  output logic [GEN_BITS-1:0] out_generation,
  output logic                out_ok
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  logic [GEN_BITS-1:0] gen_mem [MAX_SLOTS];
  logic [ID_W-1:0]     stk_mem [MAX_SLOTS];

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]    fresh_r, fresh_nxt;
  logic [1:0]          op_r;
  logic [ID_W-1:0]     id_r;
  logic [GEN_BITS-1:0] gen_r;
  logic [GEN_BITS-1:0] gen_rd_r;
  logic [ID_W-1:0]     stk_rd_r;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r;
  logic [GEN_BITS-1:0] out_gen_r;
  logic                out_ok_r;

  logic                in_xfer;
  logic                out_free;
  logic                issued;
  logic                match;
  logic                gen_re;
  logic [ID_W-1:0]     gen_ra;
  logic                gen_we;
  logic [ID_W-1:0]     gen_wa;
  logic [GEN_BITS-1:0] gen_wd;
  logic                stk_we;
  logic                load_out;
  logic [ID_W-1:0]     res_id;
  logic [GEN_BITS-1:0] res_gen;
  logic                res_ok;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign issued   = (CNT_W'(id_r) < fresh_r);
  assign match    = issued && (gen_rd_r == gen_r);

  always_comb begin
    state_nxt    = state_r;
    free_cnt_nxt = free_cnt_r;
    fresh_nxt    = fresh_r;
    gen_re       = in_xfer;
    gen_ra       = in_handle_id;
    gen_we       = 1'b0;
    gen_wa       = id_r;
    gen_wd       = gen_rd_r + GEN_BITS'(1);
    stk_we       = 1'b0;
    load_out     = 1'b0;
    res_id       = id_r;
    res_gen      = gen_r;
    res_ok       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (op_r == gha_pkg::OP_CREATE && free_cnt_r != '0) begin
          gen_re    = 1'b1;
          gen_ra    = stk_rd_r;
          state_nxt = S_POP;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            gha_pkg::OP_CREATE: begin
              if (fresh_r < MAX_CNT) begin
                res_id    = fresh_r[ID_W-1:0];
                res_gen   = '0;
                res_ok    = 1'b1;
                gen_we    = 1'b1;
                gen_wa    = fresh_r[ID_W-1:0];
                gen_wd    = '0;
                fresh_nxt = fresh_r + CNT_W'(1);
              end
            end
            gha_pkg::OP_DESTROY: begin
              if (match && free_cnt_r < MAX_CNT) begin
                res_ok       = 1'b1;
                gen_we       = 1'b1;
                stk_we       = 1'b1;
                free_cnt_nxt = free_cnt_r + CNT_W'(1);
              end
            end
            gha_pkg::OP_CHECK: begin
              res_ok = match;
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          load_out     = 1'b1;
          res_id       = stk_rd_r;
          res_gen      = gen_rd_r;
          res_ok       = 1'b1;
          free_cnt_nxt = free_cnt_r - CNT_W'(1);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (gen_re) begin
      gen_rd_r <= gen_mem[gen_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[free_cnt_r[ID_W-1:0]] <= id_r;
    end
    if (in_xfer) begin
      stk_rd_r <= stk_mem[free_cnt_r[ID_W-1:0] - ID_W'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_op;
      id_r  <= in_handle_id;
      gen_r <= in_handle_generation;
    end
    if (load_out) begin
      out_id_r  <= res_id;
      out_gen_r <= res_gen;
      out_ok_r  <= res_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_id         = out_id_r;
  assign out_generation = out_gen_r;
  assign out_ok         = out_ok_r;

  a_free_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= MAX_CNT)
    else $error("free count above slot count");

  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= MAX_CNT)
    else $error("fresh id counter above slot count");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_RD)
    else $error("request transfer did not start a memory read");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RD || $past(state_r) == S_POP))
    else $error("response loaded outside a decide cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> free_cnt_r != '0)
    else $error("pop from an empty free stack");

endmodule
